@@ rtl/core/tws_pkg.sv @@
package tws_pkg;

    localparam int ID_W    = 32;
    localparam int DL_W    = 48;
    localparam int CNT_W   = 32;
    localparam int KIND_W  = 3;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED    = 3'd0,
        KIND_DUP      = 3'd1,
        KIND_FULL     = 3'd2,
        KIND_FIRED    = 3'd3,
        KIND_OVERFLOW = 3'd4,
        KIND_DONE     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DL_W-1:0]  deadline;
        logic [CNT_W-1:0] rounds;
        logic             oneshot;
        logic [CNT_W-1:0] fires;
    } entry_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic set_valid;
        logic clr_valid;
    } store_ctl_t;

endpackage

@@ rtl/core/tws_if.sv @@
interface tws_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [tws_pkg::ID_W-1:0]   task_id;
    logic [tws_pkg::DL_W-1:0]   task_deadline;
    logic [tws_pkg::CNT_W-1:0]  task_rounds;
    logic                       task_oneshot;
    logic [tws_pkg::CNT_W-1:0]  task_fire_count;
    logic [tws_pkg::DL_W-1:0]   now_deadline;

    modport source (
        output valid, opcode, task_id, task_deadline, task_rounds, task_oneshot,
               task_fire_count, now_deadline,
        input  ready
    );
    modport sink (
        input  valid, opcode, task_id, task_deadline, task_rounds, task_oneshot,
               task_fire_count, now_deadline,
        output ready
    );
endinterface

interface tws_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [tws_pkg::KIND_W-1:0] kind;
    logic [tws_pkg::ID_W-1:0]   out_task_id;
    logic                       dispatch_async;
    logic                       repeat_task;
    logic [tws_pkg::CNT_W-1:0]  out_fire_count;
    logic                       last;

    modport source (
        output valid, kind, out_task_id, dispatch_async, repeat_task, out_fire_count,
               last,
        input  ready
    );
    modport sink (
        input  valid, kind, out_task_id, dispatch_async, repeat_task, out_fire_count,
               last,
        output ready
    );
endinterface

interface tws_cfg_if;
    logic valid;
    logic ready;
    logic async_dispatch;

    modport source (
        output valid, async_dispatch,
        input  ready
    );
    modport sink (
        input  valid, async_dispatch,
        output ready
    );
endinterface

@@ rtl/core/tws_store.sv @@
module tws_store #(
    parameter int SLOT_ENTRIES = 16,
    parameter int IDX_W        = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tws_pkg::store_ctl_t     ctl,
    input  logic [IDX_W-1:0]        wr_addr,
    input  tws_pkg::entry_t         wr_data,
    input  logic [IDX_W-1:0]        rd_addr,
    output tws_pkg::entry_t         rd_data,
    output logic [SLOT_ENTRIES-1:0] valid
);
    import tws_pkg::*;

    entry_t                  mem [SLOT_ENTRIES];
    entry_t                  rd_data_reg;
    logic [SLOT_ENTRIES-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.set_valid)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
        else if (ctl.clr_valid)
        begin
            valid_reg[wr_addr] <= 1'b0;
        end
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

@@ rtl/core/timing_wheel_slot_scan.sv @@
// One slot of a hashed timing wheel holding up to SLOT_ENTRIES tasks in an entry memory
// with one read and one write port. Every transaction on req, add or scan, walks the entries
// one per cycle through the memory read port, stalling while a fired or overflow result waits
// for rsp to take the previous one; req.ready stays low from acceptance until the closing
// result is issued. An add answers with one result; a scan answers with one result per due
// entry in entry order and a closing done result with last set. The async_dispatch register
// resets to 1; the user must write it through cfg while the block is idle, which it does not enforce.
module timing_wheel_slot_scan #(
    parameter int SLOT_ENTRIES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    tws_req_if.sink   req,
    tws_rsp_if.source rsp,
    tws_cfg_if.sink   cfg
);
    import tws_pkg::*;

    localparam int IDX_W = (SLOT_ENTRIES > 1) ? $clog2(SLOT_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_ENTRIES - 1);

    state_t             state_reg, state_next;
    logic               op_reg;
    entry_t             task_reg;
    logic [DL_W-1:0]    now_reg;
    logic               async_reg;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               dup_reg, dup_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    logic               rsp_valid_reg, rsp_valid_next;
    kind_t              rsp_kind_reg, rsp_kind_next;
    logic [ID_W-1:0]    rsp_id_reg, rsp_id_next;
    logic               rsp_dispatch_reg, rsp_dispatch_next;
    logic               rsp_repeat_reg, rsp_repeat_next;
    logic [CNT_W-1:0]   rsp_fire_count_reg, rsp_fire_count_next;
    logic               rsp_last_reg, rsp_last_next;

    store_ctl_t              ctl;
    logic [IDX_W-1:0]        wr_addr;
    entry_t                  wr_data;
    logic [IDX_W-1:0]        rd_addr;
    entry_t                  cur;
    logic [SLOT_ENTRIES-1:0] valid;

    logic accept;
    logic rsp_free;
    logic cur_valid;
    logic due;
    logic scan_hit;
    logic advance;
    logic is_last_idx;
    logic fire;

    tws_store #(
        .SLOT_ENTRIES(SLOT_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(cur),
        .valid  (valid)
    );

    assign req.ready   = (state_reg == ST_IDLE);
    assign accept      = req.valid && req.ready;
    assign cfg.ready   = 1'b1;
    assign rsp_free    = !rsp_valid_reg || rsp.ready;
    assign cur_valid   = valid[idx_reg];
    assign due         = (cur.deadline <= now_reg);
    assign fire        = (cur.rounds == '0);
    assign scan_hit    = (op_reg == OP_SCAN) && cur_valid && due;
    assign advance     = !scan_hit || rsp_free;
    assign is_last_idx = (idx_reg == LAST_IDX);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (advance && is_last_idx)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl                 = '0;
        wr_addr             = idx_reg;
        wr_data             = cur;
        rd_addr             = '0;
        idx_next            = idx_reg;
        dup_next            = dup_reg;
        free_found_next     = free_found_reg;
        free_idx_next       = free_idx_reg;
        rsp_valid_next      = rsp_valid_reg && !rsp.ready;
        rsp_kind_next       = rsp_kind_reg;
        rsp_id_next         = rsp_id_reg;
        rsp_dispatch_next   = rsp_dispatch_reg;
        rsp_repeat_next     = rsp_repeat_reg;
        rsp_fire_count_next = rsp_fire_count_reg;
        rsp_last_next       = rsp_last_reg;
        wr_data.rounds      = cur.rounds - CNT_W'(1);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctl.rd_en       = 1'b1;
                    idx_next        = '0;
                    dup_next        = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    if (!is_last_idx)
                    begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = idx_reg + IDX_W'(1);
                        idx_next  = idx_reg + IDX_W'(1);
                    end
                    if (op_reg == OP_ADD)
                    begin
                        if (cur_valid && (cur.id == task_reg.id))
                        begin
                            dup_next = 1'b1;
                        end
                        if (!cur_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                    end
                    else if (cur_valid && !due)
                    begin
                        ctl.wr_en = 1'b1;
                    end
                    else if (scan_hit)
                    begin
                        ctl.clr_valid       = fire;
                        rsp_valid_next      = 1'b1;
                        rsp_kind_next       = fire ? KIND_FIRED : KIND_OVERFLOW;
                        rsp_id_next         = cur.id;
                        rsp_dispatch_next   = fire && async_reg;
                        rsp_repeat_next     = fire && !cur.oneshot;
                        rsp_fire_count_next = !fire ? '0 :
                                              (cur.oneshot ? cur.fires : cur.fires + CNT_W'(1));
                        rsp_last_next       = 1'b0;
                    end
                end
            end
            ST_FINISH:
            begin
                wr_addr = free_idx_reg;
                wr_data = task_reg;
                if (rsp_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_dispatch_next   = 1'b0;
                    rsp_repeat_next     = 1'b0;
                    rsp_fire_count_next = '0;
                    rsp_last_next       = 1'b1;
                    if (op_reg == OP_SCAN)
                    begin
                        rsp_kind_next = KIND_DONE;
                        rsp_id_next   = '0;
                    end
                    else
                    begin
                        rsp_id_next = task_reg.id;
                        if (dup_reg)
                        begin
                            rsp_kind_next = KIND_DUP;
                        end
                        else if (!free_found_reg)
                        begin
                            rsp_kind_next = KIND_FULL;
                        end
                        else
                        begin
                            rsp_kind_next = KIND_ADDED;
                            ctl.wr_en     = 1'b1;
                            ctl.set_valid = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            async_reg      <= 1'b1;
            idx_reg        <= '0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            dup_reg        <= dup_next;
            free_found_reg <= free_found_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                async_reg <= cfg.async_dispatch;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg           <= req.opcode;
            task_reg.id       <= req.task_id;
            task_reg.deadline <= req.task_deadline;
            task_reg.rounds   <= req.task_rounds;
            task_reg.oneshot  <= req.task_oneshot;
            task_reg.fires    <= req.task_fire_count;
            now_reg          <= req.now_deadline;
        end
        free_idx_reg       <= free_idx_next;
        rsp_kind_reg       <= rsp_kind_next;
        rsp_id_reg         <= rsp_id_next;
        rsp_dispatch_reg   <= rsp_dispatch_next;
        rsp_repeat_reg     <= rsp_repeat_next;
        rsp_fire_count_reg <= rsp_fire_count_next;
        rsp_last_reg       <= rsp_last_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.kind           = rsp_kind_reg;
    assign rsp.out_task_id    = rsp_id_reg;
    assign rsp.dispatch_async = rsp_dispatch_reg;
    assign rsp.repeat_task    = rsp_repeat_reg;
    assign rsp.out_fire_count = rsp_fire_count_reg;
    assign rsp.last           = rsp_last_reg;

    a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN) && (idx_reg == '0))
        else $error("accepted transaction did not start the entry walk");

    a_finish_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && rsp_free |=>
            (state_reg == ST_IDLE) && rsp_valid_reg && rsp_last_reg)
        else $error("closing result missing after walk");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_kind_reg == KIND_DONE) |-> rsp_last_reg && (rsp_id_reg == '0))
        else $error("done result without last or with nonzero id");

    a_fired_fields_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_kind_reg != KIND_FIRED) |->
            !rsp_dispatch_reg && !rsp_repeat_reg && (rsp_fire_count_reg == '0))
        else $error("fired-only fields set on another result kind");

    a_no_emit_mid_walk_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && scan_hit && rsp_free |=> rsp_valid_reg && !rsp_last_reg)
        else $error("entry result lost or marked last");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import tws_pkg::*;

    localparam int SLOT_ENTRIES = 16;
    localparam int PHASE_ITEMS  = 96;
    localparam logic [DL_W-1:0] DL_MAX = '1;

    typedef struct {
        logic             op;
        logic [ID_W-1:0]  id;
        logic [DL_W-1:0]  deadline;
        logic [CNT_W-1:0] rounds;
        logic             oneshot;
        logic [CNT_W-1:0] fires;
        logic [DL_W-1:0]  now;
    } slot_request_t;

    typedef struct {
        kind_t            kind;
        logic [ID_W-1:0]  id;
        logic             disp;
        logic             rep;
        logic [CNT_W-1:0] fires;
        logic             last;
    } slot_result_t;

    typedef enum {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_BURSTY
    } rx_mode_t;

    logic clk;
    logic rst_n;

    tws_req_if req_ch ();
    tws_rsp_if rsp_ch ();
    tws_cfg_if cfg_ch ();

    timing_wheel_slot_scan #(
        .SLOT_ENTRIES (SLOT_ENTRIES)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Slot contents and dispatch register as the block should hold them
    logic         slot_used [SLOT_ENTRIES];
    entry_t       slot_entry [SLOT_ENTRIES];
    logic         dispatch_setting;
    slot_result_t pending_results [$];

    int error_count = 0;
    int burst_left  = 0;
    int tally_added = 0;
    int tally_dup   = 0;
    int tally_full  = 0;
    int tally_scans = 0;
    int tally_fired = 0;
    int tally_direct = 0;
    int tally_overflow = 0;

    logic [DL_W-1:0] wheel_tick = 48'd100;
    int              wheel_step = 1;
    logic [ID_W-1:0] id_pool_base = '0;
    int              add_share = 55;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [DL_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[DL_W-1:0];
    endfunction

    function automatic slot_request_t make_request(logic op, logic [ID_W-1:0] id,
                                                   logic [DL_W-1:0] deadline,
                                                   logic [CNT_W-1:0] rounds, logic oneshot,
                                                   logic [CNT_W-1:0] fires,
                                                   logic [DL_W-1:0] now);
        slot_request_t rq;
        rq.op       = op;
        rq.id       = id;
        rq.deadline = deadline;
        rq.rounds   = rounds;
        rq.oneshot  = oneshot;
        rq.fires    = fires;
        rq.now      = now;
        return rq;
    endfunction

    function automatic slot_result_t make_result(kind_t kind, logic [ID_W-1:0] id, logic disp,
                                                 logic rep, logic [CNT_W-1:0] fires,
                                                 logic last);
        slot_result_t rs;
        rs.kind  = kind;
        rs.id    = id;
        rs.disp  = disp;
        rs.rep   = rep;
        rs.fires = fires;
        rs.last  = last;
        return rs;
    endfunction

    function automatic void predict_slot(slot_request_t rq);
        int               free_idx;
        logic             hit;
        logic [CNT_W-1:0] fc;
        free_idx = -1;
        hit = 1'b0;
        if (rq.op == OP_ADD)
        begin
            for (int i = 0; i < SLOT_ENTRIES; i++)
            begin
                if (slot_used[i] && slot_entry[i].id == rq.id)
                    hit = 1'b1;
                if (!slot_used[i] && free_idx < 0)
                    free_idx = i;
            end
            if (hit)
            begin
                pending_results.push_back(make_result(KIND_DUP, rq.id, 1'b0, 1'b0, '0, 1'b1));
                tally_dup++;
            end
            else if (free_idx < 0)
            begin
                pending_results.push_back(make_result(KIND_FULL, rq.id, 1'b0, 1'b0, '0, 1'b1));
                tally_full++;
            end
            else
            begin
                slot_used[free_idx] = 1'b1;
                slot_entry[free_idx].id       = rq.id;
                slot_entry[free_idx].deadline = rq.deadline;
                slot_entry[free_idx].rounds   = rq.rounds;
                slot_entry[free_idx].oneshot  = rq.oneshot;
                slot_entry[free_idx].fires    = rq.fires;
                pending_results.push_back(make_result(KIND_ADDED, rq.id, 1'b0, 1'b0, '0, 1'b1));
                tally_added++;
            end
        end
        else
        begin
            tally_scans++;
            for (int i = 0; i < SLOT_ENTRIES; i++)
            begin
                if (slot_used[i])
                begin
                    if (slot_entry[i].deadline <= rq.now)
                    begin
                        if (slot_entry[i].rounds == '0)
                        begin
                            fc = slot_entry[i].oneshot ? slot_entry[i].fires
                                                       : slot_entry[i].fires + CNT_W'(1);
                            pending_results.push_back(make_result(KIND_FIRED, slot_entry[i].id,
                                dispatch_setting, !slot_entry[i].oneshot, fc, 1'b0));
                            slot_used[i] = 1'b0;
                            tally_fired++;
                            if (!dispatch_setting)
                                tally_direct++;
                        end
                        else
                        begin
                            pending_results.push_back(make_result(KIND_OVERFLOW,
                                slot_entry[i].id, 1'b0, 1'b0, '0, 1'b0));
                            tally_overflow++;
                        end
                    end
                    else
                    begin
                        slot_entry[i].rounds = slot_entry[i].rounds - CNT_W'(1);
                    end
                end
            end
            pending_results.push_back(make_result(KIND_DONE, '0, 1'b0, 1'b0, '0, 1'b1));
        end
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic pause_requests(int cycles);
        @(negedge clk);
        req_ch.valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_item(slot_request_t rq);
        if (burst_left == 0)
        begin
            pause_requests($urandom_range(1, 30));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid           = 1'b1;
        req_ch.opcode          = rq.op;
        req_ch.task_id         = rq.id;
        req_ch.task_deadline   = rq.deadline;
        req_ch.task_rounds     = rq.rounds;
        req_ch.task_oneshot    = rq.oneshot;
        req_ch.task_fire_count = rq.fires;
        req_ch.now_deadline    = rq.now;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predict_slot(rq);
    endtask

    task automatic wait_drained();
        pause_requests(1);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SLOT_ENTRIES + 4) @(negedge clk);
    endtask

    task automatic write_dispatch(logic value);
        wait_drained();
        @(negedge clk);
        cfg_ch.valid          = 1'b1;
        cfg_ch.async_dispatch = value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        dispatch_setting = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic slot_request_t wheel_item();
        slot_request_t rq;
        int            pick;
        int            r;
        int            live [$];
        rq = make_request(OP_ADD, $urandom, rand48(), $urandom, 1'($urandom_range(0, 1)),
                          $urandom, rand48());
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            rq.op = OP_SCAN;
        end
        else if (pick < 16)
        begin
            // reuse a live id with arbitrary fields
            foreach (slot_used[i])
                if (slot_used[i])
                    live.push_back(i);
            if (live.size() != 0)
                rq.id = slot_entry[live[$urandom_range(0, live.size() - 1)]].id;
        end
        else if (pick < add_share)
        begin
            r = $urandom_range(0, 3);
            rq.id       = id_pool_base + $urandom_range(0, 31);
            rq.deadline = wheel_tick + DL_W'(wheel_step * r)
                          + DL_W'($urandom_range(r == 0 ? 0 : 1, wheel_step));
            rq.rounds   = CNT_W'((pick < 19) ? r + 1 : r);
            if ($urandom_range(0, 7) == 0)
                rq.fires = '1;
        end
        else
        begin
            rq.op = OP_SCAN;
            wheel_tick = wheel_tick + DL_W'(wheel_step);
            rq.now = wheel_tick;
        end
        return rq;
    endfunction

    task automatic test_add_scan_extremes();
        send_item(make_request(OP_SCAN, $urandom, rand48(), $urandom, 1'b1, $urandom, '0));
        send_item(make_request(OP_ADD, '0, '0, '0, 1'b0, '1, rand48()));
        send_item(make_request(OP_ADD, '1, DL_MAX, '0, 1'b1, '1, rand48()));
        send_item(make_request(OP_ADD, '0, rand48(), $urandom, 1'b1, $urandom, rand48()));
        send_item(make_request(OP_ADD, 32'd5, 48'd100, 32'd1, 1'b1, 32'd7, rand48()));
        send_item(make_request(OP_ADD, 32'd6, DL_MAX, '1, 1'b0, 32'h1234_5678, rand48()));
        send_item(make_request(OP_SCAN, $urandom, rand48(), $urandom, 1'b0, $urandom, 48'd50));
        send_item(make_request(OP_SCAN, $urandom, rand48(), $urandom, 1'b1, $urandom, 48'd100));
        send_item(make_request(OP_ADD, '0, 48'd100, 32'd1, 1'b0, '0, rand48()));
        send_item(make_request(OP_SCAN, $urandom, rand48(), $urandom, 1'b0, $urandom, DL_MAX));
    endtask

    task automatic test_table_full();
        int free_cnt;
        free_cnt = 0;
        foreach (slot_used[i])
            if (!slot_used[i])
                free_cnt++;
        for (int n = 0; n < free_cnt; n++)
            send_item(make_request(OP_ADD, 32'hA000_0000 | ID_W'(n), DL_W'(n), '0, n[0],
                                   $urandom, rand48()));
        send_item(make_request(OP_ADD, 32'h0BAD_F00D, rand48(), $urandom, 1'b0, $urandom,
                               rand48()));
        send_item(make_request(OP_ADD, 32'd6, rand48(), $urandom, 1'b1, $urandom, rand48()));
        send_item(make_request(OP_SCAN, $urandom, rand48(), $urandom, 1'b1, $urandom, 48'd20));
    endtask

    task automatic test_random_wheel();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_dispatch(phase == 1 || (phase == 3 && $urandom_range(0, 1) == 1));
            wheel_step   = $urandom_range(1, 1000);
            id_pool_base = $urandom;
            add_share    = (phase == 2) ? 75 : 55;
            if (phase == 3)
                wheel_tick = DL_MAX - 48'd200000;
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
                send_item(wheel_item());
            end
            repeat (4)
            begin
                wheel_tick = wheel_tick + DL_W'(wheel_step);
                send_item(make_request(OP_SCAN, $urandom, rand48(), $urandom, 1'b0, $urandom,
                                       wheel_tick));
            end
            // rewind once so entries that are not due count down one round
            send_item(make_request(OP_SCAN, $urandom, rand48(), $urandom, 1'b1, $urandom, '0));
        end
    endtask

    initial
    begin : rx_pattern
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       cycle_cnt;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        cycle_cnt = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            cycle_cnt++;
            case (mode)
                RX_ALWAYS: rsp_ch.ready = 1'b1;
                RX_COIN:   rsp_ch.ready = 1'($urandom_range(0, 1));
                RX_SPARSE: rsp_ch.ready = (cycle_cnt % 4 == 0);
                default:
                begin
                    if (hold_left > 0)
                    begin
                        rsp_ch.ready = 1'b0;
                        hold_left--;
                    end
                    else
                    begin
                        rsp_ch.ready = 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            hold_left = $urandom_range(5, 20);
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        slot_result_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d id %h",
                                          rsp_ch.kind, rsp_ch.out_task_id));
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.kind !== want.kind || rsp_ch.out_task_id !== want.id
                    || rsp_ch.dispatch_async !== want.disp || rsp_ch.repeat_task !== want.rep
                    || rsp_ch.out_fire_count !== want.fires || rsp_ch.last !== want.last)
                    report_mismatch($sformatf({"expected kind %0d id %h async %b repeat %b ",
                        "fires %h last %b, got kind %0d id %h async %b repeat %b fires %h ",
                        "last %b"}, want.kind, want.id, want.disp, want.rep, want.fires,
                        want.last, rsp_ch.kind, rsp_ch.out_task_id, rsp_ch.dispatch_async,
                        rsp_ch.repeat_task, rsp_ch.out_fire_count, rsp_ch.last));
            end
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.opcode          = OP_ADD;
        req_ch.task_id         = '0;
        req_ch.task_deadline   = '0;
        req_ch.task_rounds     = '0;
        req_ch.task_oneshot    = 1'b0;
        req_ch.task_fire_count = '0;
        req_ch.now_deadline    = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.async_dispatch  = 1'b0;
        dispatch_setting       = 1'b1;
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_add_scan_extremes();
        test_table_full();
        test_random_wheel();
        wait_drained();

        $display("Run covered %0d adds stored, %0d duplicate ids and %0d adds to a full slot,",
                 tally_added, tally_dup, tally_full);
        $display("%0d scans with %0d tasks fired (%0d direct) and %0d overflow reports.",
                 tally_scans, tally_fired, tally_direct, tally_overflow);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tws_pkg.sv
rtl/core/tws_if.sv
rtl/core/tws_store.sv
rtl/core/timing_wheel_slot_scan.sv
tb/sv/tb.sv
